@@ sv/cfpb_pkg.sv @@
`default_nettype none
package cfpb_pkg;

  // crc32 generator polynomial, msb first, zero start, no final xor
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  // sync pattern at the head of every frame
  localparam logic [7:0] SYNC_0 = 8'h55;
  localparam logic [7:0] SYNC_1 = 8'h66;
  localparam logic [7:0] SYNC_2 = 8'hAA;
  localparam logic [7:0] SYNC_3 = 8'hBB;

  // highest legal control value
  localparam logic [7:0] CTRL_MAX = 8'd3;

  // byte positions within one item's output run
  localparam int unsigned IDX_W       = 5;
  localparam logic [IDX_W-1:0] POS_HCRC_0 = 5'd12;
  localparam logic [IDX_W-1:0] POS_HCRC_1 = 5'd13;
  localparam logic [IDX_W-1:0] POS_HCRC_2 = 5'd14;
  localparam logic [IDX_W-1:0] POS_HDR_END = 5'd15;
  localparam logic [IDX_W-1:0] POS_HDR_LEN = 5'd16;
  localparam logic [1:0]       TRL_LAST    = 2'd3;

  // one input item
  typedef struct packed {
    logic        mode;
    logic [7:0]  control;
    logic [15:0] sequence_req;
    logic [7:0]  command;
    logic [15:0] pay_len;
    logic [7:0]  payload_byte;
  } cfpb_item_t;

  // one result byte with its markers
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       frame_end;
    logic       rejected;
  } cfpb_res_t;

  // fold one byte into the crc, msb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ sv/cfpb_emit.sv @@
`default_nettype none
module cfpb_emit #(
  parameter int unsigned MAX_PAYLOAD = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_valid,
  input  wire cfpb_pkg::cfpb_item_t item,
  output logic                     item_ready,
  input  wire logic                slot_free,
  output logic                     res_valid,
  output cfpb_pkg::cfpb_res_t      res
);
  import cfpb_pkg::*;

  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  // current item and its progress
  cfpb_item_t       cur_r;
  logic             cur_vld_r;
  logic [IDX_W-1:0] idx_r;

  // frame state
  logic        frame_open_r;
  logic [15:0] bytes_left_r;
  logic [31:0] crc_r;
  logic [31:0] hcrc_r;

  logic        rej;
  logic        ignore;
  logic        go;
  logic        last;
  logic        fold;
  logic        trl;
  logic [1:0]  tpos;
  logic [7:0]  hdr_byte;
  logic [7:0]  byte_val;
  logic [31:0] crc_base;
  logic [31:0] crc_fold;

  assign rej    = (cur_r.control > CTRL_MAX) || (cur_r.pay_len > MAX_LEN);
  assign ignore = cur_r.mode && !frame_open_r;
  assign go     = cur_vld_r && (ignore || slot_free);

  // header byte by position
  always_comb begin
    case (idx_r[3:0])
      4'd0:            hdr_byte = SYNC_0;
      4'd1:            hdr_byte = SYNC_1;
      4'd2:            hdr_byte = SYNC_2;
      4'd3:            hdr_byte = SYNC_3;
      4'd4:            hdr_byte = cur_r.control;
      4'd5:            hdr_byte = cur_r.pay_len[7:0];
      4'd6:            hdr_byte = cur_r.pay_len[15:8];
      4'd9:            hdr_byte = cur_r.sequence_req[7:0];
      4'd10:           hdr_byte = cur_r.sequence_req[15:8];
      4'd11:           hdr_byte = cur_r.command;
      POS_HCRC_0[3:0]: hdr_byte = crc_r[7:0];
      POS_HCRC_1[3:0]: hdr_byte = hcrc_r[15:8];
      POS_HCRC_2[3:0]: hdr_byte = hcrc_r[23:16];
      POS_HDR_END[3:0]: hdr_byte = hcrc_r[31:24];
      default:         hdr_byte = 8'h00;
    endcase
  end

  // byte selection and run markers
  always_comb begin
    tpos     = cur_r.mode ? 2'(idx_r[1:0] - 2'd1) : idx_r[1:0];
    trl      = 1'b0;
    fold     = 1'b0;
    last     = 1'b0;
    byte_val = 8'h00;
    if (!cur_r.mode) begin
      if (rej) begin
        last = 1'b1;
      end else if (idx_r < POS_HDR_LEN) begin
        byte_val = hdr_byte;
        fold     = 1'b1;
        last     = (idx_r == POS_HDR_END) && (cur_r.pay_len != 16'd0);
      end else begin
        trl = 1'b1;
      end
    end else if (idx_r == '0) begin
      byte_val = cur_r.payload_byte;
      fold     = 1'b1;
      last     = (bytes_left_r != 16'd1);
    end else begin
      trl = 1'b1;
    end
    if (trl) begin
      byte_val = crc_r[8*tpos +: 8];
      last     = (tpos == TRL_LAST);
    end
    crc_base = (!cur_r.mode && idx_r == '0) ? 32'h0 : crc_r;
    crc_fold = crc_byte(crc_base, byte_val);
  end

  assign item_ready    = !cur_vld_r || (go && (last || ignore));
  assign res_valid     = go && !ignore;
  assign res.out_byte  = byte_val;
  assign res.run_end   = last;
  assign res.frame_end = trl && last;
  assign res.rejected  = !cur_r.mode && rej;

  // item holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
    end else if (item_valid && item_ready) begin
      cur_vld_r <= 1'b1;
    end else if (go && (last || ignore)) begin
      cur_vld_r <= 1'b0;
    end
    if (item_valid && item_ready) begin
      cur_r <= item;
    end
  end

  // sequencer and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      frame_open_r <= 1'b0;
      bytes_left_r <= 16'd0;
      crc_r        <= 32'h0;
    end else if (go && !ignore) begin
      idx_r <= last ? '0 : IDX_W'(idx_r + 1'b1);
      if (!cur_r.mode && rej) begin
        frame_open_r <= 1'b0;
        bytes_left_r <= 16'd0;
        crc_r        <= 32'h0;
      end else if (fold) begin
        crc_r <= crc_fold;
        if (!cur_r.mode && idx_r == '0) begin
          frame_open_r <= 1'b0;
          bytes_left_r <= 16'd0;
        end
        if (!cur_r.mode && last) begin
          frame_open_r <= 1'b1;
          bytes_left_r <= cur_r.pay_len;
        end
        if (cur_r.mode) begin
          bytes_left_r <= 16'(bytes_left_r - 16'd1);
        end
      end else if (trl && last) begin
        frame_open_r <= 1'b0;
        bytes_left_r <= 16'd0;
        crc_r        <= 32'h0;
      end
    end
  end

  // snapshot of the header crc while its bytes go out
  always_ff @(posedge clk) begin
    if (go && !ignore && !cur_r.mode && idx_r == POS_HCRC_0) begin
      hcrc_r <= crc_r;
    end
  end

endmodule
`default_nettype wire

@@ sv/cfpb_out.sv @@
`default_nettype none
module cfpb_out (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               res_valid,
  input  wire cfpb_pkg::cfpb_res_t res,
  output logic                    slot_free,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [7:0]              out_tdata,
  output logic                    out_tlast,
  output logic [1:0]              out_tuser
);
  import cfpb_pkg::*;

  logic      vld_r;
  cfpb_res_t res_r;

  assign slot_free = !vld_r || out_tready;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (slot_free) begin
      vld_r <= res_valid;
    end
    if (slot_free && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = res_r.out_byte;
  assign out_tlast  = res_r.run_end;
  assign out_tuser  = {res_r.rejected, res_r.frame_end};

endmodule
`default_nettype wire

@@ sv/crc32_framed_packet_builder.sv @@
`default_nettype none
// Framed packet builder: a start transfer (in_tuser = 0) yields a 16-byte header
// (sync 55 66 AA BB, control, 32-bit length, 16-bit sequence, command, header
// crc32) and, for a zero length, the 4-byte frame crc32 straight after; a
// payload transfer (in_tuser = 1) yields its byte, plus the 4-byte frame crc32
// when it is the last one. A start with control above 3 or length above
// MAX_PAYLOAD yields one byte flagged rejected. Bytes leave at one per cycle
// while out_tready allows, through a single output register; an item yields
// 1 byte for a payload byte or a rejection, 5 for a closing payload byte, 16
// or 20 for a start; a payload transfer with no open frame is dropped with no
// output. The next item is taken in the cycle its predecessor's last byte is
// produced, so payload streams at one byte per cycle unless out_tready stalls
// it. Crc32 uses polynomial 04C11DB7, zero start, msb first, no reflection,
// no final xor, and all multi-byte fields are little-endian.
module crc32_framed_packet_builder #(
  parameter int unsigned MAX_PAYLOAD = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // control[7:0], sequence_req[23:8], command[31:24], pay_len[47:32],
  // payload_byte[55:48]
  input  wire logic [55:0] in_tdata,
  // mode[0]
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_byte[7:0]
  output logic [7:0]       out_tdata,
  // run_end
  output logic             out_tlast,
  // frame_end[0], rejected[1]
  output logic [1:0]       out_tuser
);
  import cfpb_pkg::*;

  cfpb_item_t item;
  cfpb_res_t  res;
  logic       res_valid;
  logic       slot_free;

  // unpack the input transfer
  assign item.mode           = in_tuser[0];
  assign item.control        = in_tdata[7:0];
  assign item.sequence_req   = in_tdata[23:8];
  assign item.command        = in_tdata[31:24];
  assign item.pay_len        = in_tdata[47:32];
  assign item.payload_byte   = in_tdata[55:48];

  cfpb_emit #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(in_tvalid),
    .item      (item),
    .item_ready(in_tready),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res)
  );

  cfpb_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // a rejection is a lone zero byte that closes its run
  a_reject_form : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && out_tdata == 8'h00 && !out_tuser[0])
    else $error("rejected result malformed");

  // the frame crc always closes the run of its item
  a_frame_end_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("frame end without run end");

  // nothing leaves straight after reset
  a_reset_quiet : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire
